>>> rtl/hamming_sec_codec_unit_macros.svh
// assertion macros for the hamming sec codec checker
`ifndef HAMMING_SEC_CODEC_UNIT_MACROS_SVH
`define HAMMING_SEC_CODEC_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hsc_pkg.sv
// shared types, constants and bit-placement functions for the hamming sec codec
package hsc_pkg;

  localparam int CODE_W = 63;
  localparam int LEN_W  = 6;
  localparam int SYN_W  = 6;
  localparam int MAX_CODE_BITS_DEF = 63;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_SYN_RANGE = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_t;

  // ones in the low n bit positions
  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W:0] n);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  // smallest r >= 1 with 2^r >= k + r + 1, saturating at 7
  function automatic logic [2:0] enc_check_bits(input logic [LEN_W-1:0] k);
    logic [2:0] r;
    r = 3'd7;
    for (int j = 6; j >= 1; j--) begin
      if ((1 << j) >= int'(k) + j + 1) begin
        r = 3'(j);
      end
    end
    return r;
  endfunction

  // data bits in order onto the positions that are not powers of two
  function automatic logic [CODE_W-1:0] scatter_data(input logic [CODE_W-1:0] d);
    logic [CODE_W-1:0] w;
    int di;
    w  = '0;
    di = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = d[di];
        di++;
      end
    end
    return w;
  endfunction

endpackage

>>> rtl/hamming_sec_codec_unit.sv
// top level of the hamming single-error-correcting encoder and decoder
// usage
//   input channel: in_valid, in_stall and the request fields in_func, in_payload,
//   in_length; a request is taken on a clock edge with in_valid high and in_stall low
//   in_func selects encode (data bits to codeword) or decode (codeword to corrected
//   codeword); bit 0 of the payload is codeword position 1
//   result channel: out_valid, out_stall and out_word, out_length, out_syndrome,
//   out_status; exactly one result per request, in request order
//   pipeline: three register stages (length decode and data placement, parity
//   trees, correction and status); out_valid and the result fields are registered
//   throughput: one request per cycle while out_stall is low, set by the three-stage
//   pipeline
//   stall: each stage holds while the one after it is full and stalled, so a
//   stalled result stays put while empty stages upstream keep filling; in_stall
//   rises only once every stage is occupied
//   reset: rst_n low at a clock edge empties every stage; no other state exists
//   MAX_CODE_BITS bounds the codeword length accepted on either direction
module hamming_sec_codec_unit
  import hsc_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [CODE_W-1:0] in_payload,
  input  logic [LEN_W-1:0]  in_length,
  // result side
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_word,
  output logic [LEN_W-1:0]  out_length,
  output logic [SYN_W-1:0]  out_syndrome,
  output logic [1:0]        out_status
);

  // stage valid bits
  logic s1_valid_r, s2_valid_r, out_valid_r;

  // stage 1: placed or masked word and length check
  logic              s1_func_r, s1_func_nxt;
  logic              s1_bad_r, s1_bad_nxt;
  logic [CODE_W-1:0] s1_word_r, s1_word_nxt;
  logic [LEN_W-1:0]  s1_len_r, s1_len_nxt;

  // stage 2: syndrome alongside the word
  logic              s2_func_r;
  logic              s2_bad_r;
  logic [CODE_W-1:0] s2_word_r;
  logic [LEN_W-1:0]  s2_len_r;
  logic [SYN_W-1:0]  s2_syn_r, s2_syn_nxt;

  // stage 3: output register
  logic [CODE_W-1:0] out_word_r, out_word_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [SYN_W-1:0]  out_syn_r, out_syn_nxt;
  status_t           out_status_r, out_status_nxt;

  // a stage may load when it is empty or its contents move on this cycle
  logic rdy_out, rdy2, rdy1;
  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy2     = !s2_valid_r || rdy_out;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  // ---------------------------------------------------------------- stage 1
  logic [2:0]       enc_r;
  logic [LEN_W:0]   enc_n;
  logic             enc_ok, dec_ok;

  assign enc_r  = enc_check_bits(in_length);
  assign enc_n  = {1'b0, in_length} + {4'b0000, enc_r};
  assign enc_ok = (in_length != '0) && (enc_n <= (LEN_W+1)'(MAX_CODE_BITS));
  assign dec_ok = (in_length != '0) && ({1'b0, in_length} <= (LEN_W+1)'(MAX_CODE_BITS));

  always_comb begin
    s1_func_nxt = in_func;
    s1_bad_nxt  = 1'b0;
    s1_word_nxt = '0;
    s1_len_nxt  = '0;
    unique case (in_func)
      FUNC_ENCODE: begin
        if (enc_ok) begin
          s1_word_nxt = scatter_data(in_payload & low_mask({1'b0, in_length}));
          s1_len_nxt  = enc_n[LEN_W-1:0];
        end else begin
          s1_bad_nxt = 1'b1;
        end
      end
      FUNC_DECODE: begin
        if (dec_ok) begin
          s1_word_nxt = in_payload & low_mask({1'b0, in_length});
          s1_len_nxt  = in_length;
        end else begin
          s1_bad_nxt = 1'b1;
        end
      end
      default: begin
        s1_bad_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      s1_func_r <= s1_func_nxt;
      s1_bad_r  <= s1_bad_nxt;
      s1_word_r <= s1_word_nxt;
      s1_len_r  <= s1_len_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // for an encode, parity bits above the check count are zero, since every position fits below 2^r
  hsc_syndrome u_syndrome (
    .word (s1_word_r),
    .syn  (s2_syn_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
    if (rdy2 && s1_valid_r) begin
      s2_func_r <= s1_func_r;
      s2_bad_r  <= s1_bad_r;
      s2_word_r <= s1_word_r;
      s2_len_r  <= s1_len_r;
      s2_syn_r  <= s2_syn_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // one-hot flip at the position named by the syndrome
  logic [CODE_W-1:0] flip;
  always_comb begin
    for (int p = 0; p < CODE_W; p++) begin
      flip[p] = (s2_syn_r == SYN_W'(p + 1));
    end
  end

  always_comb begin
    out_word_nxt   = s2_word_r;
    out_len_nxt    = s2_len_r;
    out_syn_nxt    = s2_syn_r;
    out_status_nxt = ST_OK;
    priority if (s2_bad_r) begin
      out_word_nxt   = '0;
      out_len_nxt    = '0;
      out_syn_nxt    = '0;
      out_status_nxt = ST_BAD_LEN;
    end else if (s2_func_r == FUNC_ENCODE) begin
      // parity bit i goes to position 2^i
      for (int i = 0; i < SYN_W; i++) begin
        out_word_nxt[(1 << i) - 1] = s2_word_r[(1 << i) - 1] | s2_syn_r[i];
      end
    end else if (s2_syn_r == '0) begin
      out_status_nxt = ST_OK;
    end else if (s2_syn_r > s2_len_r) begin
      // syndrome points past the codeword: report, leave the word alone
      out_status_nxt = ST_SYN_RANGE;
    end else begin
      out_word_nxt   = s2_word_r ^ flip;
      out_status_nxt = ST_CORRECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= s2_valid_r;
    end
    if (rdy_out && s2_valid_r) begin
      out_word_r   <= out_word_nxt;
      out_len_r    <= out_len_nxt;
      out_syn_r    <= out_syn_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign out_length   = out_len_r;
  assign out_syndrome = out_syn_r;
  assign out_status   = out_status_r;

endmodule

>>> rtl/hsc_syndrome.sv
// parity trees: bit i is the xor over all codeword positions with index bit i set
module hsc_syndrome
  import hsc_pkg::*;
(
  input  logic [CODE_W-1:0] word,
  output logic [SYN_W-1:0]  syn
);

  always_comb begin
    logic acc;
    syn = '0;
    for (int i = 0; i < SYN_W; i++) begin
      acc = 1'b0;
      for (int p = 1; p <= CODE_W; p++) begin
        if (((p >> i) & 1) != 0) begin
          acc = acc ^ word[p-1];
        end
      end
      syn[i] = acc;
    end
  end

endmodule

>>> rtl/hsc_checker.sv
// port-level checks on the codec results and their binding to the top level
`include "hamming_sec_codec_unit_macros.svh"

module hsc_checker
  import hsc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CODE_W-1:0] out_word,
  input logic [LEN_W-1:0]  out_length,
  input logic [SYN_W-1:0]  out_syndrome,
  input logic [1:0]        out_status
);

  // a rejected length yields an all-zero result
  `HSC_ASSERT_NOW(a_bad_len_zero, out_valid && out_status == ST_BAD_LEN, out_word == '0 && out_length == '0 && out_syndrome == '0, "bad length result not cleared")

  // nothing above the reported length
  `HSC_ASSERT_NOW(a_word_in_length, out_valid, (out_word >> out_length) == '0, "word bits beyond length")

  // a correction names a position inside the codeword
  `HSC_ASSERT_NOW(a_corr_in_range, out_valid && out_status == ST_CORRECTED, out_syndrome != '0 && out_syndrome <= out_length, "correction outside codeword")

  // an out-of-range flag really is out of range
  `HSC_ASSERT_NOW(a_syn_beyond, out_valid && out_status == ST_SYN_RANGE, out_syndrome > out_length, "syndrome flagged but in range")

  // a stalled result holds
  `HSC_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind hamming_sec_codec_unit hsc_checker u_hsc_checker (.*);
